>>> rtl/hrsp_pkg.sv
// Shared types and constants for the HTTP request stream parser.
`default_nettype none
package hrsp_pkg;
    localparam logic [1:0] KIND_REQLINE = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_BAD_LINE  = 2'd0;
    localparam logic [1:0] ERR_NO_COLON  = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd2;
    localparam logic [1:0] ERR_PUT_NOLEN = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int KEY_LEN = 14;

    // byte of "Content-Length" at position i
    function automatic logic [7:0] cl_key_byte(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = 8'h43;  4'd1: c = 8'h6f;  4'd2: c = 8'h6e;  4'd3: c = 8'h74;
            4'd4: c = 8'h65;  4'd5: c = 8'h6e;  4'd6: c = 8'h74;  4'd7: c = 8'h2d;
            4'd8: c = 8'h4c;  4'd9: c = 8'h65;  4'd10: c = 8'h6e; 4'd11: c = 8'h67;
            4'd12: c = 8'h74; 4'd13: c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] put_byte(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0: c = 8'h50;
            2'd1: c = 8'h55;
            2'd2: c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // one result beat; widths fixed by the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [15:0] first_offset;
        logic [15:0] first_length;
        logic [15:0] second_offset;
        logic [15:0] second_length;
        logic [31:0] content_length;
        logic [5:0]  headers_parsed;
        logic [15:0] total_length;
    } t_result;

    // classified byte from the front end
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_sp;
        logic       is_blank;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
    } t_cls;
endpackage
`default_nettype wire

>>> rtl/http_request_stream_parser_core.sv
// Top level of the HTTP request stream parser: config port, front end, back end.
//  channel | dir | handshake       | payload
//  input   | in  | i_valid/o_stall | i_data_byte, i_start_req
//  result  | out | o_valid/i_stall | o_kind .. o_total_length
//  config  | in  | APB             | max_headers @0, put_needs_length @4
// One byte per cycle sustained while the result side does not stall. A byte accepted
// goes into the front-end queue; the back end parses it from there and registers its
// result, if any, in the output register. A stalled result holds the parser; the
// two-entry queue takes beats until it is full, then o_stall rises.
// Reset (synchronous) clears the parser to idle and restores 32 / 1 in the registers.
`default_nettype none
module http_request_stream_parser_core #(
    parameter int MAX_HEADER_SLOTS = 32,
    parameter int OFFSET_BITS      = 16,
    parameter int LENGTH_BITS      = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_start_req,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_error_code,
    output logic [15:0] o_first_offset,
    output logic [15:0] o_first_length,
    output logic [15:0] o_second_offset,
    output logic [15:0] o_second_length,
    output logic [31:0] o_content_length,
    output logic [5:0]  o_headers_parsed,
    output logic [15:0] o_total_length,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] ADDR_MAXH = 3'd0;
    localparam logic [2:0] ADDR_PUT  = 3'd4;

    logic [5:0] r_max_headers;
    logic       r_put_needs;
    logic       q_valid, q_pop;
    hrsp_pkg::t_cls q_data;
    hrsp_pkg::t_result res;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_headers <= 6'd32;
            r_put_needs   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_MAXH) r_max_headers <= pwdata[5:0];
            else if (paddr == ADDR_PUT) r_put_needs <= pwdata[0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MAXH) prdata = {26'd0, r_max_headers};
        else if (paddr == ADDR_PUT) prdata = {31'd0, r_put_needs};
    end

    hrsp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_start_req,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    hrsp_back #(
        .MAX_HEADER_SLOTS(MAX_HEADER_SLOTS), .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .i_max_headers(r_max_headers), .i_put_needs_length(r_put_needs),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_kind           = res.kind;
    assign o_error_code     = res.error_code;
    assign o_first_offset   = res.first_offset;
    assign o_first_length   = res.first_length;
    assign o_second_offset  = res.second_offset;
    assign o_second_length  = res.second_length;
    assign o_content_length = res.content_length;
    assign o_headers_parsed = res.headers_parsed;
    assign o_total_length   = res.total_length;
endmodule
`default_nettype wire

>>> rtl/hrsp_front.sv
// Front end: accepts input beats and classifies each byte into a small queue.
`default_nettype none
module hrsp_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  wire  [7:0]      i_data_byte,
    input  wire             i_start_req,
    output logic            o_q_valid,
    input  wire             i_q_pop,
    output hrsp_pkg::t_cls  o_q_data
);
    // two-entry queue
    hrsp_pkg::t_cls r_ent [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    hrsp_pkg::t_cls w_c;
    logic push;

    always_comb begin
        w_c.data     = i_data_byte;
        w_c.start    = i_start_req;
        w_c.is_sp    = i_data_byte == hrsp_pkg::CH_SP;
        w_c.is_blank = i_data_byte == hrsp_pkg::CH_SP || i_data_byte == hrsp_pkg::CH_TAB;
        w_c.is_colon = i_data_byte == hrsp_pkg::CH_COLON;
        w_c.is_cr    = i_data_byte == hrsp_pkg::CH_CR;
        w_c.is_lf    = i_data_byte == hrsp_pkg::CH_LF;
        w_c.is_digit = i_data_byte >= hrsp_pkg::CH_ZERO && i_data_byte <= hrsp_pkg::CH_NINE;
        w_c.digit    = 4'(i_data_byte - hrsp_pkg::CH_ZERO);
    end

    assign o_stall   = r_cnt == 2'd2;
    assign push      = i_valid && !o_stall;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_data  = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop && o_q_valid) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop && o_q_valid);
        end
        if (push) r_ent[r_wr] <= w_c;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_q_pop) |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !push) |=> r_cnt == 2'd0)
        else $error("entry appeared without a push");
endmodule
`default_nettype wire

>>> rtl/hrsp_back.sv
// Back end: parser state machine and registered result beat.
`default_nettype none
module hrsp_back #(
    parameter int MAX_HEADER_SLOTS = 32,
    parameter int OFFSET_BITS      = 16,
    parameter int LENGTH_BITS      = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    output logic              o_q_pop,
    input  hrsp_pkg::t_cls    i_q_data,
    input  wire  [5:0]        i_max_headers,
    input  wire               i_put_needs_length,
    output logic              o_valid,
    input  wire               i_stall,
    output hrsp_pkg::t_result o_res
);
    localparam logic [2:0] PH_IDLE = 3'd0, PH_REQ = 3'd1, PH_HDR = 3'd2,
                           PH_PAY = 3'd3, PH_DONE = 3'd4, PH_ERR = 3'd5;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] SAT_TH = LEN_MAX / 10;
    localparam logic [3:0] SAT_DIG = 4'(LEN_MAX % 10);
    localparam logic [6:0] SLOTS = 7'(MAX_HEADER_SLOTS > 63 ? 63 : MAX_HEADER_SLOTS);
    localparam logic [4:0] KEY_END = 5'(hrsp_pkg::KEY_LEN);

    logic [2:0] r_ph, n_ph;
    logic r_pcr, n_pcr, r_skip, n_skip, r_kmatch, n_kmatch, r_lfound, n_lfound;
    logic r_dig, n_dig;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_ls, n_ls, r_fae, n_fae, r_vb, n_vb;
    logic [1:0] r_dlm, n_dlm, r_put, n_put;
    logic [4:0] r_kidx, n_kidx;
    logic [LENGTH_BITS-1:0] r_acc, n_acc, r_rem, n_rem;
    logic [5:0] r_hs, n_hs;
    hrsp_pkg::t_result n_res;
    logic n_emit;

    // the output register frees when empty or taken
    assign o_q_pop = i_q_valid && (!o_valid || !i_stall);

    always_comb begin
        logic [OFFSET_BITS-1:0] cur, nxt, crpos, uri;
        logic eol;
        logic [6:0] limit;
        logic [2:0] ph;
        logic [LENGTH_BITS-1:0] clen;
        hrsp_pkg::t_cls c;
        c = i_q_data;
        n_ph = r_ph; n_pcr = r_pcr; n_skip = r_skip; n_kmatch = r_kmatch;
        n_lfound = r_lfound; n_dig = r_dig; n_off = r_off; n_ls = r_ls; n_fae = r_fae;
        n_vb = r_vb; n_dlm = r_dlm; n_put = r_put; n_kidx = r_kidx; n_acc = r_acc;
        n_rem = r_rem; n_hs = r_hs;
        n_emit = 1'b0;
        n_res = '0;
        if (c.start) begin
            n_pcr = 1'b0; n_off = '0; n_ls = '0; n_dlm = '0; n_kidx = '0; n_kmatch = 1'b1;
            n_skip = 1'b0; n_dig = 1'b0; n_fae = '0; n_vb = '0; n_lfound = 1'b0;
            n_acc = '0; n_hs = '0; n_put = '0; n_rem = '0; n_ph = PH_REQ;
        end
        ph = n_ph;
        cur = n_off;
        nxt = cur + 1'b1;
        crpos = cur - 1'b1;
        uri = n_fae + 1'b1;
        eol = n_pcr && c.is_lf;
        limit = {1'b0, i_max_headers} < SLOTS ? {1'b0, i_max_headers} : SLOTS;
        if (ph == PH_REQ || ph == PH_HDR || ph == PH_PAY) begin
            n_off = nxt;
            n_pcr = c.is_cr;
        end
        unique case (ph)
            PH_PAY: begin
                n_rem = n_rem - 1'b1;
                if (n_rem == '0) begin
                    n_ph = PH_DONE; n_emit = 1'b1;
                    n_res.kind = hrsp_pkg::KIND_DONE;
                    n_res.total_length = 16'(nxt);
                end
            end
            PH_REQ: begin
                if (cur < OFFSET_BITS'(3) && OFFSET_BITS'(n_put) == cur
                    && c.data == hrsp_pkg::put_byte(2'(cur)))
                    n_put = n_put + 2'd1;
                if (eol) begin
                    n_emit = 1'b1;
                    if (n_dlm < 2'd2) begin
                        n_ph = PH_ERR;
                        n_res.kind = hrsp_pkg::KIND_ERROR;
                        n_res.error_code = hrsp_pkg::ERR_BAD_LINE;
                    end else begin
                        n_ph = PH_HDR;
                        n_res.kind = hrsp_pkg::KIND_REQLINE;
                        n_res.first_offset  = 16'(n_ls);
                        n_res.first_length  = 16'(n_fae - n_ls);
                        n_res.second_offset = 16'(uri);
                        n_res.second_length = 16'(n_vb - uri);
                        n_ls = nxt; n_dlm = '0; n_kidx = '0; n_kmatch = 1'b1;
                        n_skip = 1'b0; n_dig = 1'b0;
                    end
                end else if (c.is_sp) begin
                    if (n_dlm == 2'd0) begin n_fae = cur; n_dlm = 2'd1; end
                    else if (n_dlm == 2'd1) begin n_vb = cur; n_dlm = 2'd2; end
                end
            end
            PH_HDR: begin
                if (eol) begin
                    if (crpos == n_ls) begin
                        if (n_put == 2'd3 && i_put_needs_length && !n_lfound) begin
                            n_emit = 1'b1; n_ph = PH_ERR;
                            n_res.kind = hrsp_pkg::KIND_ERROR;
                            n_res.error_code = hrsp_pkg::ERR_PUT_NOLEN;
                        end else begin
                            n_rem = n_lfound ? n_acc : '0;
                            if (n_rem == '0) begin
                                n_emit = 1'b1; n_ph = PH_DONE;
                                n_res.kind = hrsp_pkg::KIND_DONE;
                                n_res.total_length = 16'(nxt);
                            end else n_ph = PH_PAY;
                        end
                    end else if ({1'b0, n_hs} >= limit) begin
                        n_emit = 1'b1; n_ph = PH_ERR;
                        n_res.kind = hrsp_pkg::KIND_ERROR;
                        n_res.error_code = hrsp_pkg::ERR_TOO_MANY;
                    end else if (n_dlm == 2'd0) begin
                        n_emit = 1'b1; n_ph = PH_ERR;
                        n_res.kind = hrsp_pkg::KIND_ERROR;
                        n_res.error_code = hrsp_pkg::ERR_NO_COLON;
                    end else begin
                        n_emit = 1'b1;
                        n_res.kind = hrsp_pkg::KIND_HEADER;
                        n_res.first_offset  = 16'(n_ls);
                        n_res.first_length  = 16'(n_fae - n_ls);
                        n_res.second_offset = 16'(n_vb);
                        n_res.second_length = 16'(crpos - n_vb);
                        n_hs = n_hs + 6'd1;
                        n_ls = nxt; n_dlm = '0; n_kidx = '0; n_kmatch = 1'b1;
                        n_skip = 1'b0; n_dig = 1'b0;
                    end
                end else if (n_dlm == 2'd0) begin
                    if (c.is_colon) begin
                        n_dlm = 2'd1; n_fae = cur; n_vb = nxt; n_skip = 1'b1;
                        if (n_kmatch && n_kidx == KEY_END && !n_lfound) begin
                            n_lfound = 1'b1; n_acc = '0; n_dig = 1'b1;
                        end
                    end else if (n_kidx < KEY_END
                                 && c.data == hrsp_pkg::cl_key_byte(4'(n_kidx))) begin
                        n_kidx = n_kidx + 5'd1;
                    end else n_kmatch = 1'b0;
                end else begin
                    if (n_skip && c.is_blank) n_vb = nxt;
                    else begin
                        n_skip = 1'b0;
                        if (n_dig) begin
                            if (c.is_digit) begin
                                // saturating acc*10+d without a divider
                                if (n_acc > SAT_TH || (n_acc == SAT_TH && c.digit > SAT_DIG))
                                    n_acc = LEN_MAX;
                                else
                                    n_acc = (n_acc << 3) + (n_acc << 1)
                                          + LENGTH_BITS'(c.digit);
                            end else n_dig = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        clen = n_lfound ? n_acc : '0;
        n_res.content_length = 32'(clen);
        n_res.headers_parsed = n_hs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_pcr <= 1'b0; r_off <= '0; r_ls <= '0; r_dlm <= '0;
            r_fae <= '0; r_vb <= '0; r_skip <= 1'b0; r_kidx <= '0; r_kmatch <= 1'b1;
            r_lfound <= 1'b0; r_acc <= '0; r_dig <= 1'b0; r_hs <= '0; r_put <= '0;
            r_rem <= '0; o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_ph <= n_ph; r_pcr <= n_pcr; r_off <= n_off; r_ls <= n_ls; r_dlm <= n_dlm;
                r_fae <= n_fae; r_vb <= n_vb; r_skip <= n_skip; r_kidx <= n_kidx;
                r_kmatch <= n_kmatch; r_lfound <= n_lfound; r_acc <= n_acc; r_dig <= n_dig;
                r_hs <= n_hs; r_put <= n_put; r_rem <= n_rem;
                o_valid <= n_emit;
            end else if (!i_stall) o_valid <= 1'b0;
        end
        if (o_q_pop && n_emit) o_res <= n_res;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_res))
        else $error("stalled result changed");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !o_q_pop)
        else $error("popped while result blocked");
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hs} <= SLOTS)
        else $error("header count beyond slots");
endmodule
`default_nettype wire

>>> sim/http_request_stream_parser_core_test.sv
// Self-checking testbench for the HTTP request stream parser core.
`timescale 1ns / 1ps
module http_request_stream_parser_core_test;
    localparam int  CYCLE_LIMIT     = 1000000;
    localparam int  SETTLE_CYCLES   = 10;
    localparam int  HEADER_SLOTS    = 32;
    localparam logic [2:0] REG_MAX_HEADERS = 3'd0;
    localparam logic [2:0] REG_PUT_NEEDS_LEN = 3'd1;

    typedef enum logic [2:0] {
        PS_IDLE, PS_REQLINE, PS_HEADERS, PS_PAYLOAD, PS_DONE, PS_FAILED
    } t_parse_state;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_beat;

    logic        i_clk, i_rst_n;
    logic        i_valid, i_stall, o_stall, o_valid;
    logic [7:0]  i_data_byte;
    logic        i_start_req;
    logic [1:0]  o_kind, o_error_code;
    logic [15:0] o_first_offset, o_first_length, o_second_offset, o_second_length;
    logic [31:0] o_content_length;
    logic [5:0]  o_headers_parsed;
    logic [15:0] o_total_length;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    http_request_stream_parser_core dut (.*);

    t_beat   pending_beats[$];
    hrsp_pkg::t_result expected_results[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      sender_idle_pct = 0;
    int      stall_pct = 0;
    bit      driving = 0;
    bit      beat_taken = 0;

    // parser shadow state
    logic [5:0]   cfg_max_headers = 6'd32;
    logic         cfg_put_needs_len = 1'b1;
    t_parse_state pstate = PS_IDLE;
    logic         saw_cr, skip_blanks, key_ok, len_found, in_digits;
    logic [15:0]  pos, line_begin, key_end, val_begin;
    logic [1:0]   delims, put_match;
    logic [4:0]   key_pos;
    logic [31:0]  len_acc, body_left;
    logic [5:0]   hdr_count;

    string key_word = "Content-Length";
    string put_word = "PUT";

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic void start_line(input logic [15:0] at);
        line_begin  = at;
        delims      = 2'd0;
        key_pos     = 5'd0;
        key_ok      = 1'b1;
        skip_blanks = 1'b0;
        in_digits   = 1'b0;
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [1:0] code,
                                       input logic [15:0] f0, input logic [15:0] f1,
                                       input logic [15:0] f2, input logic [15:0] f3,
                                       input logic [15:0] total);
        hrsp_pkg::t_result r;
        r.kind           = k;
        r.error_code     = code;
        r.first_offset   = f0;
        r.first_length   = f1;
        r.second_offset  = f2;
        r.second_length  = f3;
        r.content_length = len_found ? len_acc : 32'd0;
        r.headers_parsed = hdr_count;
        r.total_length   = total;
        expected_results.push_back(r);
    endfunction

    function automatic void fail_request(input logic [1:0] code);
        pstate = PS_FAILED;
        add_result(hrsp_pkg::KIND_ERROR, code, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic st);
        logic [15:0] cur, nxt, crpos, uri;
        logic        at_eol;
        int          limit;
        logic [63:0] d;
        if (st) begin
            saw_cr = 1'b0; pos = 16'd0; start_line(16'd0);
            key_end = 16'd0; val_begin = 16'd0; len_found = 1'b0; len_acc = 32'd0;
            hdr_count = 6'd0; put_match = 2'd0; body_left = 32'd0;
            pstate = PS_REQLINE;
        end
        if (pstate != PS_REQLINE && pstate != PS_HEADERS && pstate != PS_PAYLOAD) return;
        cur = pos;
        nxt = cur + 16'd1;
        crpos = cur - 16'd1;
        at_eol = saw_cr && b == hrsp_pkg::CH_LF;
        pos = nxt;
        saw_cr = (b == hrsp_pkg::CH_CR);

        if (pstate == PS_PAYLOAD) begin
            body_left = body_left - 32'd1;
            if (body_left == 32'd0) begin
                pstate = PS_DONE;
                add_result(hrsp_pkg::KIND_DONE, hrsp_pkg::ERR_BAD_LINE,
                           16'd0, 16'd0, 16'd0, 16'd0, nxt);
            end
            return;
        end

        if (pstate == PS_REQLINE) begin
            if (cur < 16'd3 && put_match == cur[1:0] && b == put_word[cur])
                put_match = put_match + 2'd1;
            if (at_eol) begin
                if (delims < 2'd2) begin
                    fail_request(hrsp_pkg::ERR_BAD_LINE);
                    return;
                end
                uri = key_end + 16'd1;
                pstate = PS_HEADERS;
                add_result(hrsp_pkg::KIND_REQLINE, hrsp_pkg::ERR_BAD_LINE, line_begin,
                           key_end - line_begin, uri, val_begin - uri, 16'd0);
                start_line(nxt);
                return;
            end
            if (b == hrsp_pkg::CH_SP) begin
                if (delims == 2'd0) begin
                    key_end = cur; delims = 2'd1;
                end else if (delims == 2'd1) begin
                    val_begin = cur; delims = 2'd2;
                end
            end
            return;
        end

        if (at_eol) begin
            if (crpos == line_begin) begin
                if (put_match == 2'd3 && cfg_put_needs_len && !len_found) begin
                    fail_request(hrsp_pkg::ERR_PUT_NOLEN);
                    return;
                end
                body_left = len_found ? len_acc : 32'd0;
                if (body_left == 32'd0) begin
                    pstate = PS_DONE;
                    add_result(hrsp_pkg::KIND_DONE, hrsp_pkg::ERR_BAD_LINE,
                               16'd0, 16'd0, 16'd0, 16'd0, nxt);
                end else begin
                    pstate = PS_PAYLOAD;
                end
                return;
            end
            limit = cfg_max_headers < HEADER_SLOTS ? cfg_max_headers : HEADER_SLOTS;
            if (hdr_count >= limit) begin
                fail_request(hrsp_pkg::ERR_TOO_MANY);
                return;
            end
            if (delims == 2'd0) begin
                fail_request(hrsp_pkg::ERR_NO_COLON);
                return;
            end
            hdr_count = hdr_count + 6'd1;
            add_result(hrsp_pkg::KIND_HEADER, hrsp_pkg::ERR_BAD_LINE, line_begin,
                       key_end - line_begin, val_begin, crpos - val_begin, 16'd0);
            start_line(nxt);
            return;
        end

        if (delims == 2'd0) begin
            if (b == hrsp_pkg::CH_COLON) begin
                delims = 2'd1;
                key_end = cur;
                val_begin = nxt;
                skip_blanks = 1'b1;
                if (key_ok && key_pos == 5'd14 && !len_found) begin
                    len_found = 1'b1; len_acc = 32'd0; in_digits = 1'b1;
                end
            end else if (key_pos < 5'd14 && b == key_word[key_pos]) begin
                key_pos = key_pos + 5'd1;
            end else begin
                key_ok = 1'b0;
            end
            return;
        end

        if (skip_blanks) begin
            if (b == hrsp_pkg::CH_SP || b == hrsp_pkg::CH_TAB) begin
                val_begin = nxt;
                return;
            end
            skip_blanks = 1'b0;
        end
        if (in_digits) begin
            if (b >= hrsp_pkg::CH_ZERO && b <= hrsp_pkg::CH_NINE) begin
                d = 64'(b - hrsp_pkg::CH_ZERO);
                if (64'(len_acc) > (64'hFFFF_FFFF - d) / 10) len_acc = 32'hFFFF_FFFF;
                else len_acc = 32'(64'(len_acc) * 10 + d);
            end else begin
                in_digits = 1'b0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // input acceptance, result checking and timeout
    always @(posedge i_clk) begin
        hrsp_pkg::t_result w;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            beat_taken = i_rst_n && i_valid && !o_stall;
            if (beat_taken) parse_byte(i_data_byte, i_start_req);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, kind", o_kind, -1);
                end else begin
                    w = expected_results.pop_front();
                    check_field("kind", o_kind, w.kind);
                    check_field("error_code", o_error_code, w.error_code);
                    check_field("first_offset", o_first_offset, w.first_offset);
                    check_field("first_length", o_first_length, w.first_length);
                    check_field("second_offset", o_second_offset, w.second_offset);
                    check_field("second_length", o_second_length, w.second_length);
                    check_field("content_length", o_content_length, w.content_length);
                    check_field("headers_parsed", o_headers_parsed, w.headers_parsed);
                    check_field("total_length", o_total_length, w.total_length);
                end
            end
        end
    end

    // byte driver and result-side stall
    always @(negedge i_clk) begin
        t_beat nb;
        if (!driving) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
            if (i_valid && !beat_taken) begin
                // hold the stalled beat
            end else if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nb = pending_beats.pop_front();
                i_valid     <= 1'b1;
                i_data_byte <= nb.data;
                i_start_req <= nb.start;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic push_text(input string s, input bit st);
        t_beat nb;
        for (int i = 0; i < s.len(); i++) begin
            nb.data = s[i];
            nb.start = (i == 0) ? st : 1'b0;
            pending_beats.push_back(nb);
        end
    endtask

    task automatic push_random_bytes(input int n, input int start_pct);
        t_beat nb;
        for (int i = 0; i < n; i++) begin
            nb.data = 8'($urandom);
            nb.start = ($urandom_range(99) < start_pct);
            pending_beats.push_back(nb);
        end
    endtask

    function automatic string random_token(input int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(33, 126)))};
        return s;
    endfunction

    task automatic push_random_request();
        string s, mth, key, val;
        int nh, clv, sel;
        bit have_len;
        if ($urandom_range(99) < 8) begin
            push_random_bytes($urandom_range(1, 8), 20);
            return;
        end
        case ($urandom_range(5))
            0: mth = "GET";
            1, 2: mth = "PUT";
            3: mth = "POST";
            4: mth = "PU";
            default: mth = random_token($urandom_range(1, 5));
        endcase
        s = {mth, " /", random_token($urandom_range(0, 5))};
        if ($urandom_range(99) < 5) s = {s, "\r"};
        if ($urandom_range(99) >= 6) s = {s, " HTTP/1.1"};
        s = {s, "\r\n"};
        nh = ($urandom_range(99) < 5) ? $urandom_range(5, 34) : $urandom_range(0, 4);
        have_len = 0;
        clv = 0;
        for (int h = 0; h < nh; h++) begin
            sel = $urandom_range(99);
            if (sel < 40) key = "Content-Length";
            else if (sel < 50) key = "Content-Lengt";
            else if (sel < 55) key = "Content-Lengthh";
            else if (sel < 60) key = "content-length";
            else key = random_token($urandom_range(1, 6));
            if ($urandom_range(99) < 4) begin
                s = {s, key, "\r\n"};
                continue;
            end
            val = "";
            repeat ($urandom_range(0, 3)) val = {val, ($urandom_range(1) ? " " : "\t")};
            if (key == "Content-Length") begin
                sel = $urandom_range(0, 6);
                if (!have_len) clv = sel;
                have_len = 1;
                if ($urandom_range(99) < 3) val = {val, "98765432101234"};
                else val = {val, ($urandom_range(3) == 0) ? "0" : "", $sformatf("%0d", sel)};
                if ($urandom_range(99) < 10) val = {val, ";x 7"};
            end else begin
                val = {val, random_token($urandom_range(0, 6))};
            end
            if ($urandom_range(99) < 10) val = {val, "  "};
            s = {s, key, ":", val, "\r\n"};
        end
        if ($urandom_range(99) < 92) s = {s, "\r\n"};
        push_text(s, 1'b1);
        push_random_bytes(($urandom_range(99) < 5) ? $urandom_range(0, 3) : clv, 0);
        if ($urandom_range(99) < 10) push_random_bytes($urandom_range(1, 3), 0);
    endtask

    task automatic push_random_phase(input int n);
        int target;
        target = pending_beats.size() + n;
        while (pending_beats.size() < target) push_random_request();
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(idx * 4); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MAX_HEADERS) cfg_max_headers = v[5:0];
        else cfg_put_needs_len = v[0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_config(input int mh, input int pnl, input int idle, input int stl);
        drain();
        write_register(REG_MAX_HEADERS, 32'(mh));
        write_register(REG_PUT_NEEDS_LEN, 32'(pnl));
        sender_idle_pct = idle;
        stall_pct = stl;
    endtask

    initial begin
        string hdrs;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_data_byte = 8'd0; i_start_req = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 3'd0; pwdata = 32'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        driving = 1;

        // directed requests at reset settings
        push_random_bytes(3, 0);                      // ignored while idle
        push_text("GET /a HTTP/1.1\r\nHost: x\r\n\r\n", 1'b1);
        push_text("PUT /f HTTP/1.1\r\n\r\n", 1'b1);   // PUT with no length
        push_text("PUT /f HTTP/1.1\r\nContent-Length:\t 2\r\n\r\nab", 1'b1);
        push_text("POST /p HTTP/1.1\r\ncontent-length: 3\r\n\r\n", 1'b1);
        push_text("POST /p HTTP/1.1\r\nContent-Length: 3\r\nContent-Length: 9\r\n\r\nxyz",
                  1'b1);
        push_text("BAD\r\n", 1'b1);                  // one field only
        push_text("GET / HTTP/1.1\r\nNoColonHere\r\n", 1'b1);
        push_text("GET /\rx\n HTTP/1.1\r\nK:\r\n\r\n", 1'b1); // lone CR and LF
        push_text("GET /half HTTP/1.1\r\nHost: y", 1'b1);      // restart mid-request
        push_text("GET /sat HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\nzz", 1'b1);
        push_text("\xff\x01 \x80\x7f \r\n\r\n", 1'b1);
        push_text(" \r\n", 1'b1);
        hdrs = "GET /many HTTP/1.1\r\n";
        repeat (33) hdrs = {hdrs, "H: v\r\n"};
        push_text({hdrs, "\r\n"}, 1'b1);
        push_text("GET / HTTP/1.1\r\nA:1\r\n\r\nleftover", 1'b1);
        drain();

        set_config(2, 1, 52, 0);
        push_random_phase(180);
        set_config(0, 0, 0, 52);
        push_text("PUT / HTTP/1.1\r\n\r\n", 1'b1);
        push_text("GET / HTTP/1.1\r\nA: b\r\n\r\n", 1'b1);
        push_random_phase(180);
        set_config(63, 1, 10, 10);
        push_random_phase(180);
        set_config(1, 0, 0, 0);
        push_random_phase(180);
        drain();                                      // wait until all beats are sent and all results in

        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/hrsp_pkg.sv
rtl/hrsp_front.sv
rtl/hrsp_back.sv
rtl/http_request_stream_parser_core.sv
sim/http_request_stream_parser_core_test.sv
